// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define PBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define PBS_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/pbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbs_pkg;

   localparam int BURST_W   = 16;
   localparam int PRIO_W    = 8;
   localparam int JOB_NUM_W = 6;
   localparam int TIME_W    = 21;
   // The accumulated waiting total wraps at this width.
   localparam int RUN_W     = 27;

   localparam int REQ_FIELDS_W = BURST_W + PRIO_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = JOB_NUM_W + BURST_W + 4 * TIME_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== rtl/pbs_job_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbs_job_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 30
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] job_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         job_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= job_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pbs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbs_div #(
   parameter int DIVIDEND_W = 27,
   parameter int DIVISOR_W  = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output      logic                  done,
   output      logic [DIVIDEND_W-1:0] quotient
);

   localparam int StepW = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [StepW-1:0]      step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // Restoring division: one quotient bit per cycle, dividend shifted in from the top.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = StepW'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - StepW'(1);
         if (step_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/priority_batch_scheduler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Non-preemptive priority scheduler for one batch of up to MAX_JOBS jobs.
// The req channel takes one job per word: burst time and priority in tdata, tlast
// on the final job. Jobs are numbered from 1 in arrival order; a batch also ends
// when the job store is full.
// After the batch closes, the jobs are sorted by ascending priority with a
// selection sort in the job memory, then one rsp word per job is sent in that
// order with its waiting and turnaround time. The last word of the batch carries
// tlast and the floored averages.
// The averages take two serial divisions. The sort is bound by the single read
// port of the job memory, one entry per cycle.
// A new batch is taken as soon as the last result sits in the output register.
// When the receiver stalls, the result stays in the output register and the
// block waits. Reset empties the open batch and the output register; the
// memory contents are not cleared.
module priority_batch_scheduler_top #(
   parameter int MAX_JOBS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   // burst_time [15:0], priority_req [23:16]
   input  wire logic [pbs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           req_tlast,
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // job_number [5:0], burst_out [21:6], waiting_time [42:22],
   // turnaround_time [63:43], avg_waiting [84:64], avg_turnaround [105:85]
   output      logic [pbs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic                           rsp_tlast
);

   import pbs_pkg::*;

   localparam int IdxC   = $clog2(MAX_JOBS);
   localparam int IdxW   = (MAX_JOBS > 1) ? IdxC : 1;
   localparam int CntW   = $clog2(MAX_JOBS + 1);
   localparam int WaitW  = IdxC + BURST_W;
   localparam int TatW   = 2 * IdxC + BURST_W;
   localparam int DivW   = (RUN_W > TatW) ? RUN_W : TatW;
   localparam int EntryW = BURST_W + PRIO_W + CntW;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_START,
      ST_SCAN,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_EMIT_RD,
      ST_EMIT_USE,
      ST_DIV_W,
      ST_DIV_W_WAIT,
      ST_DIV_T,
      ST_DIV_T_WAIT,
      ST_EMIT_LAST
   } state_type;

   state_type             state_ff, state_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic [CntW-1:0]       n_ff, n_in;
   logic [CntW-1:0]       i_ff, i_in;
   logic [CntW-1:0]       j_ff, j_in;
   logic [CntW-1:0]       k_ff, k_in;
   logic [IdxW-1:0]       rd_idx_ff, rd_idx_in;
   logic [IdxW-1:0]       pos_ff, pos_in;
   logic [EntryW-1:0]     cur_ff, cur_in;
   logic [EntryW-1:0]     min_ff, min_in;
   logic [WaitW-1:0]      wait_ff, wait_in;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [TatW-1:0]       tat_tot_ff, tat_tot_in;
   logic [TIME_W-1:0]     avg_w_ff, avg_w_in;
   logic [TIME_W-1:0]     avg_t_ff, avg_t_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tlast_ff, rsp_tlast_in;

   logic                  wr_en;
   logic [IdxW-1:0]       wr_addr;
   logic [EntryW-1:0]     wr_data;
   logic                  rd_en;
   logic [IdxW-1:0]       rd_addr;
   logic [EntryW-1:0]     rd_data;

   logic                  div_start;
   logic [DivW-1:0]       div_dividend;
   logic                  div_done;
   logic [DivW-1:0]       div_quo;

   logic                  req_accept;
   logic                  slot_free;
   logic                  rsp_load;
   logic                  rsp_last;
   logic [TIME_W-1:0]     out_avg_w;
   logic [TIME_W-1:0]     out_avg_t;
   logic [BURST_W-1:0]    rd_burst;
   logic [PRIO_W-1:0]     rd_prio;
   logic [CntW-1:0]       rd_num;
   logic [PRIO_W-1:0]     min_prio;
   logic [WaitW-1:0]      tat_sum;

   pbs_job_ram #(
      .DEPTH  (MAX_JOBS),
      .ADDR_W (IdxW),
      .DATA_W (EntryW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pbs_div #(
      .DIVIDEND_W (DivW),
      .DIVISOR_W  (CntW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   assign rd_burst = rd_data[BURST_W-1:0];
   assign rd_prio  = rd_data[BURST_W +: PRIO_W];
   assign rd_num   = rd_data[BURST_W + PRIO_W +: CntW];
   assign min_prio = min_ff[BURST_W +: PRIO_W];
   assign tat_sum  = wait_ff + WaitW'(rd_burst);

   // Memory accesses are strictly sequenced by the state machine: the swap writes
   // finish before the next scan reads, so no forwarding is needed.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rd_idx_in    = rd_idx_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      min_in       = min_ff;
      wait_in      = wait_ff;
      run_in       = run_ff;
      tat_tot_in   = tat_tot_ff;
      avg_w_in     = avg_w_ff;
      avg_t_in     = avg_t_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff[IdxW-1:0];
      wr_data      = {cnt_ff + CntW'(1), req_tdata[BURST_W +: PRIO_W],
                      req_tdata[BURST_W-1:0]};
      rd_en        = 1'b0;
      rd_addr      = k_ff[IdxW-1:0];
      div_start    = 1'b0;
      div_dividend = DivW'(run_ff);
      rsp_load     = 1'b0;
      rsp_last     = 1'b0;
      out_avg_w    = '0;
      out_avg_t    = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               wr_en = 1'b1;
               if (req_tlast || (cnt_ff == CntW'(MAX_JOBS - 1))) begin
                  n_in     = cnt_ff + CntW'(1);
                  cnt_in   = '0;
                  i_in     = '0;
                  state_in = ST_SORT_START;
               end else begin
                  cnt_in = cnt_ff + CntW'(1);
               end
            end
         end
         ST_SORT_START: begin
            if ((i_ff + CntW'(1)) >= n_ff) begin
               k_in       = '0;
               wait_in    = '0;
               run_in     = '0;
               tat_tot_in = '0;
               state_in   = ST_EMIT_RD;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = i_ff[IdxW-1:0];
               rd_idx_in = i_ff[IdxW-1:0];
               j_in      = i_ff + CntW'(1);
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The first word of a scan is the entry at position i itself.
            if (rd_idx_ff == i_ff[IdxW-1:0]) begin
               cur_in = rd_data;
               min_in = rd_data;
               pos_in = rd_idx_ff;
            end else if (rd_prio < min_prio) begin
               min_in = rd_data;
               pos_in = rd_idx_ff;
            end
            if (j_ff < n_ff) begin
               rd_en     = 1'b1;
               rd_addr   = j_ff[IdxW-1:0];
               rd_idx_in = j_ff[IdxW-1:0];
               j_in      = j_ff + CntW'(1);
            end else begin
               state_in = ST_SWAP_A;
            end
         end
         ST_SWAP_A: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff[IdxW-1:0];
            wr_data  = min_ff;
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = cur_ff;
            i_in     = i_ff + CntW'(1);
            state_in = ST_SORT_START;
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff[IdxW-1:0];
            state_in = ST_EMIT_USE;
         end
         ST_EMIT_USE: begin
            if (k_ff == (n_ff - CntW'(1))) begin
               // The last job's entry stays in the read register until it is sent.
               run_in     = run_ff + RUN_W'(wait_ff);
               tat_tot_in = tat_tot_ff + TatW'(tat_sum);
               state_in   = ST_DIV_W;
            end else if (slot_free) begin
               rsp_load   = 1'b1;
               run_in     = run_ff + RUN_W'(wait_ff);
               tat_tot_in = tat_tot_ff + TatW'(tat_sum);
               wait_in    = tat_sum;
               k_in       = k_ff + CntW'(1);
               state_in   = ST_EMIT_RD;
            end
         end
         ST_DIV_W: begin
            div_start    = 1'b1;
            div_dividend = DivW'(run_ff);
            state_in     = ST_DIV_W_WAIT;
         end
         ST_DIV_W_WAIT: begin
            if (div_done) begin
               avg_w_in = TIME_W'(div_quo);
               state_in = ST_DIV_T;
            end
         end
         ST_DIV_T: begin
            div_start    = 1'b1;
            div_dividend = DivW'(tat_tot_ff);
            state_in     = ST_DIV_T_WAIT;
         end
         ST_DIV_T_WAIT: begin
            if (div_done) begin
               avg_t_in = TIME_W'(div_quo);
               state_in = ST_EMIT_LAST;
            end
         end
         ST_EMIT_LAST: begin
            if (slot_free) begin
               rsp_load  = 1'b1;
               rsp_last  = 1'b1;
               out_avg_w = avg_w_ff;
               out_avg_t = avg_t_ff;
               state_in  = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_DATA_W'({out_avg_t, out_avg_w, TIME_W'(tat_sum),
                                      TIME_W'(wait_ff), rd_burst, JOB_NUM_W'(rd_num)});
         rsp_tlast_in  = rsp_last;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         cnt_ff        <= '0;
         n_ff          <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         n_ff          <= n_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      pos_ff       <= pos_in;
      cur_ff       <= cur_in;
      min_ff       <= min_in;
      wait_ff      <= wait_in;
      run_ff       <= run_in;
      tat_tot_ff   <= tat_tot_in;
      avg_w_ff     <= avg_w_in;
      avg_t_ff     <= avg_t_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `PBS_ASSERT(a_load_room, (state_ff == ST_LOAD) |-> (cnt_ff < CntW'(MAX_JOBS)), "store overrun")
   `PBS_ASSERT(a_scan_range, (state_ff == ST_SCAN) |-> (CntW'(rd_idx_ff) < n_ff && i_ff < n_ff), "scan index out of batch")
   `PBS_ASSERT(a_swap_pos, (state_ff == ST_SWAP_A) |-> (CntW'(pos_ff) >= i_ff && CntW'(pos_ff) < n_ff), "minimum position out of range")
   `PBS_ASSERT(a_emit_range, (state_ff == ST_EMIT_USE) |-> (k_ff < n_ff), "result index out of batch")
   `PBS_ASSERT_NEXT(a_last_word, state_ff == ST_EMIT_LAST && rsp_load, rsp_tvalid && rsp_tlast && state_ff == ST_LOAD, "last word not marked")

endmodule

`default_nettype wire

// ===== dv/priority_batch_scheduler_top_test.sv =====
`timescale 1ns / 1ps

module priority_batch_scheduler_top_test;
   import pbs_pkg::*;

   localparam int MAX_JOBS    = 32;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 100;
   localparam int RANDOM_JOBS = 56;

   localparam int NUM_LSB  = 0;
   localparam int BURST_LSB = NUM_LSB + JOB_NUM_W;
   localparam int WAIT_LSB = BURST_LSB + BURST_W;
   localparam int TAT_LSB  = WAIT_LSB + TIME_W;
   localparam int AVGW_LSB = TAT_LSB + TIME_W;
   localparam int AVGT_LSB = AVGW_LSB + TIME_W;

   typedef struct {
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic               last;
   } job_word_type;

   typedef struct {
      logic [JOB_NUM_W-1:0] job_number;
      logic [BURST_W-1:0]   burst_out;
      logic [TIME_W-1:0]    waiting_time;
      logic [TIME_W-1:0]    turnaround_time;
      logic [TIME_W-1:0]    avg_waiting;
      logic [TIME_W-1:0]    avg_turnaround;
      logic                 end_of_schedule;
   } schedule_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   priority_batch_scheduler_top #(.MAX_JOBS(MAX_JOBS)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   job_word_type       jobs_to_send[$];
   schedule_entry_type schedule_due[$];

   // Open batch as the scheduler holds it.
   logic [BURST_W-1:0]   batch_burst[MAX_JOBS];
   logic [PRIO_W-1:0]    batch_prio[MAX_JOBS];
   logic [JOB_NUM_W-1:0] batch_number[MAX_JOBS];
   int                   batch_jobs = 0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int jobs_accepted  = 0;
   int batches_closed = 0;
   int full_closes    = 0;
   int entries_seen   = 0;
   int idle_cycles    = 0;

   task automatic log_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input int unsigned got,
                                input int unsigned want);
      if (got != want)
         log_mismatch($sformatf("entry %0d %s: got %0d, expected %0d",
                                entries_seen, name, got, want));
   endtask

   task automatic add_job(input int burst, input int prio, input bit last);
      job_word_type w;
      w.burst = BURST_W'(burst);
      w.prio  = PRIO_W'(prio);
      w.last  = last;
      jobs_to_send.push_back(w);
   endtask

   // Selection sort that swaps the first strict minimum into place, then
   // the waiting and turnaround bookkeeping for the whole batch.
   task automatic close_batch(input bit by_full_store);
      int unsigned n, i, j, pos, waiting, tat, tat_total, wait_total;
      logic [BURST_W-1:0]   tb;
      logic [PRIO_W-1:0]    tp;
      logic [JOB_NUM_W-1:0] tn;
      schedule_entry_type   e;
      n = batch_jobs;
      for (i = 0; i < n; i++) begin
         pos = i;
         for (j = i + 1; j < n; j++)
            if (batch_prio[j] < batch_prio[pos])
               pos = j;
         tb = batch_burst[i];
         tp = batch_prio[i];
         tn = batch_number[i];
         batch_burst[i]    = batch_burst[pos];
         batch_prio[i]     = batch_prio[pos];
         batch_number[i]   = batch_number[pos];
         batch_burst[pos]  = tb;
         batch_prio[pos]   = tp;
         batch_number[pos] = tn;
      end
      waiting    = 0;
      tat_total  = 0;
      wait_total = 0;
      for (i = 0; i < n; i++) begin
         tat = waiting + batch_burst[i];
         wait_total = (wait_total + waiting) & ((1 << RUN_W) - 1);
         tat_total  = tat_total + tat;
         e.job_number      = batch_number[i];
         e.burst_out       = batch_burst[i];
         e.waiting_time    = waiting[TIME_W-1:0];
         e.turnaround_time = tat[TIME_W-1:0];
         e.avg_waiting     = '0;
         e.avg_turnaround  = '0;
         e.end_of_schedule = 1'b0;
         if (i == n - 1) begin
            e.avg_waiting     = TIME_W'(wait_total / n);
            e.avg_turnaround  = TIME_W'(tat_total / n);
            e.end_of_schedule = 1'b1;
         end
         schedule_due.push_back(e);
         waiting = tat;
      end
      batch_jobs = 0;
      batches_closed++;
      if (by_full_store)
         full_closes++;
   endtask

   task automatic take_job(input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                           input logic last);
      batch_burst[batch_jobs]  = burst;
      batch_prio[batch_jobs]   = prio;
      batch_number[batch_jobs] = JOB_NUM_W'(batch_jobs + 1);
      batch_jobs++;
      jobs_accepted++;
      if (last || batch_jobs == MAX_JOBS)
         close_batch(!last);
   endtask

   // Driver: a word leaves the queue only once the previous one was taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            take_job(req_tdata[BURST_W-1:0], req_tdata[BURST_W +: PRIO_W], req_tlast);
         if (!req_tvalid || req_tready) begin
            if (jobs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata  <= REQ_DATA_W'({jobs_to_send[0].prio, jobs_to_send[0].burst});
               req_tlast  <= jobs_to_send[0].last;
               req_tvalid <= 1'b1;
               void'(jobs_to_send.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      schedule_entry_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (schedule_due.size() == 0) begin
               log_mismatch($sformatf("unexpected result word, job %0d",
                                      rsp_tdata[NUM_LSB +: JOB_NUM_W]));
            end else begin
               e = schedule_due.pop_front();
               compare_field("job_number", rsp_tdata[NUM_LSB +: JOB_NUM_W], e.job_number);
               compare_field("burst_out", rsp_tdata[BURST_LSB +: BURST_W], e.burst_out);
               compare_field("waiting_time", rsp_tdata[WAIT_LSB +: TIME_W], e.waiting_time);
               compare_field("turnaround_time", rsp_tdata[TAT_LSB +: TIME_W],
                             e.turnaround_time);
               compare_field("avg_waiting", rsp_tdata[AVGW_LSB +: TIME_W], e.avg_waiting);
               compare_field("avg_turnaround", rsp_tdata[AVGT_LSB +: TIME_W],
                             e.avg_turnaround);
               compare_field("end_of_schedule", rsp_tlast, e.end_of_schedule);
            end
            entries_seen++;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a handshake", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic int pick_burst();
      case ($urandom_range(9))
         0:       return 0;
         1:       return 65535;
         2:       return $urandom_range(15);
         default: return $urandom_range(65535);
      endcase
   endfunction

   // Queues one batch; a batch of MAX_JOBS without any last flag closes on
   // the full store.
   task automatic queue_batch(input int jobs, input bit no_last);
      int k, prio_mode, prio;
      prio_mode = $urandom_range(3);
      for (k = 0; k < jobs; k++) begin
         case (prio_mode)
            0:       prio = $urandom_range(3);
            1:       prio = $urandom_range(1) ? 255 : $urandom_range(2);
            default: prio = $urandom_range(255);
         endcase
         add_job(pick_burst(), prio, (k == jobs - 1) && !no_last);
      end
   endtask

   // Sampled at the falling edge so that the queues and req_tvalid are settled.
   task automatic drain();
      while (jobs_to_send.size() != 0 || schedule_due.size() != 0 || req_tvalid)
         @(negedge clock);
   endtask

   initial begin
      int phase, queued, len, pick;
      int idle_plan[4];
      int stall_plan[4];
      idle_plan  = '{0, 46, 0, 32};
      stall_plan = '{0, 0, 46, 32};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single jobs at both extremes.
      add_job(65535, 255, 1'b1);
      add_job(0, 0, 1'b1);
      // Ties: the swap moves job 1 behind job 3.
      add_job(10, 3, 1'b0);
      add_job(20, 1, 1'b0);
      add_job(30, 3, 1'b0);
      add_job(40, 1, 1'b1);
      // Strictly falling priorities, mostly widest bursts.
      add_job(65535, 255, 1'b0);
      add_job(65535, 200, 1'b0);
      add_job(1, 100, 1'b0);
      add_job(65535, 1, 1'b0);
      add_job(0, 0, 1'b1);
      // All equal priority keeps arrival order.
      for (int k = 0; k < 6; k++)
         add_job(100 * (k + 1), 7, k == 5);
      // Large totals feed the averages.
      add_job(65535, 0, 1'b0);
      add_job(65535, 128, 1'b0);
      add_job(65535, 64, 1'b1);

      for (phase = 0; phase < 4; phase++) begin
         drain();
         send_idle_pct  = idle_plan[phase];
         recv_stall_pct = stall_plan[phase];
         queued = 0;
         if (phase % 2 == 1) begin
            queue_batch(MAX_JOBS, phase == 1);
            queued = MAX_JOBS;
         end
         while (queued < RANDOM_JOBS) begin
            pick = $urandom_range(19);
            if (pick < 14)
               len = $urandom_range(8, 1);
            else if (pick < 19)
               len = $urandom_range(MAX_JOBS - 1, 9);
            else
               len = MAX_JOBS;
            queue_batch(len, len == MAX_JOBS && $urandom_range(1));
            queued += len;
         end
      end

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (schedule_due.size() != 0)
         log_mismatch($sformatf("%0d result words never arrived", schedule_due.size()));
      $display("Sent %0d jobs in %0d batches (%0d closed by a full store), checked %0d words.",
               jobs_accepted, batches_closed, full_closes, entries_seen);
      $display("Ran four handshake phases with sender gaps and receiver stalls; %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pbs_pkg.sv
rtl/pbs_job_ram.sv
rtl/pbs_div.sv
rtl/priority_batch_scheduler_top.sv
dv/priority_batch_scheduler_top_test.sv
